// File: hdl/u8d_pkg.sv
// shared types, constants and helper functions of the strict utf-8 decoder
// no dependencies; imported by every other file of the block
package u8d_pkg;

    localparam int OFFSET_BITS_DEF = 16;
    localparam int QUEUE_DEPTH     = 2;
    localparam int CP_BITS         = 21;
    localparam int LEN_BITS        = 3;

    // byte class as seen by the front end
    typedef enum logic [2:0] {
        CLS_ASCII,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_BAD
    } u8d_kind_t;

    // extra range check owed by the first continuation byte
    typedef enum logic [2:0] {
        CHK_NONE,
        CHK_E0,
        CHK_ED,
        CHK_F0,
        CHK_F4
    } u8d_chk_t;

    // classified byte as queued between front and back
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        u8d_kind_t  kind;
        u8d_chk_t   chk;
        logic       cont;
        logic       lt_a0;
        logic       lt_90;
        logic       gt_8f;
    } u8d_class_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } u8d_qstat_t;

    function automatic logic in_space_set(input logic [CP_BITS-1:0] c);
        logic hit;
        hit = (c == 21'h00009) || (c == 21'h00020) || (c == 21'h000A0) ||
              (c == 21'h01680) || ((c >= 21'h02000) && (c <= 21'h0200A)) ||
              (c == 21'h0202F) || (c == 21'h0205F) || (c == 21'h03000);
        return hit;
    endfunction

    function automatic logic is_break(input logic [CP_BITS-1:0] c);
        return (c == 21'h0000A) || (c == 21'h0000D);
    endfunction

endpackage

// File: hdl/u8d_front.sv
// front end: accepts text bytes, classifies them and tags each with its offset
// depends on u8d_pkg
module u8d_front #(
    parameter int OFFSET_BITS = u8d_pkg::OFFSET_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // data_byte
    input  logic                   s_tlast,   // end_of_text
    input  u8d_pkg::u8d_qstat_t    qstat,
    output logic                   push,
    output u8d_pkg::u8d_class_t    cls,
    output logic [OFFSET_BITS-1:0] offset
);
    import u8d_pkg::*;

    logic [OFFSET_BITS-1:0] pos_reg, pos_next;

    assign s_tready = !qstat.full;
    assign push     = s_tvalid && !qstat.full;
    assign offset   = pos_reg;

    always_comb begin
        cls       = '0;
        cls.data  = s_tdata;
        cls.last  = s_tlast;
        cls.cont  = (s_tdata[7:6] == 2'b10);
        cls.lt_a0 = (s_tdata < 8'hA0);
        cls.lt_90 = (s_tdata < 8'h90);
        cls.gt_8f = (s_tdata > 8'h8F);
        cls.chk   = CHK_NONE;
        unique case (s_tdata) inside
            [8'h00:8'h7F]: cls.kind = CLS_ASCII;
            [8'hC2:8'hDF]: cls.kind = CLS_LEAD2;
            [8'hE0:8'hEF]: cls.kind = CLS_LEAD3;
            [8'hF0:8'hF4]: cls.kind = CLS_LEAD4;
            default:       cls.kind = CLS_BAD;
        endcase
        unique case (s_tdata)
            8'hE0:   cls.chk = CHK_E0;
            8'hED:   cls.chk = CHK_ED;
            8'hF0:   cls.chk = CHK_F0;
            8'hF4:   cls.chk = CHK_F4;
            default: cls.chk = CHK_NONE;
        endcase
    end

    // saturating offset, back to zero after the final byte
    always_comb begin
        pos_next = pos_reg;
        if (push) begin
            if (s_tlast)
                pos_next = '0;
            else if (pos_reg != {OFFSET_BITS{1'b1}})
                pos_next = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

endmodule

// File: hdl/u8d_fifo.sv
// small register queue between the classifier and the decoder
// depends on u8d_pkg
module u8d_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = u8d_pkg::QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  logic [WIDTH-1:0]    din,
    input  logic                pop,
    output logic [WIDTH-1:0]    dout,
    output u8d_pkg::u8d_qstat_t qstat
);
    import u8d_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [IW-1:0]    wr_reg, wr_next, rd_reg, rd_next;
    logic [CW-1:0]    cnt_reg, cnt_next;

    assign qstat.full  = (cnt_reg == CW'(DEPTH));
    assign qstat.empty = (cnt_reg == '0);
    assign dout        = mem_reg[rd_reg];

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == IW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        if (pop)
            rd_next = (rd_reg == IW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (push)
            mem_reg[wr_reg] <= din;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: hdl/u8d_back.sv
// back end: sequence decoder with strict checks and the result register
// depends on u8d_pkg
module u8d_back #(
    parameter int OFFSET_BITS = u8d_pkg::OFFSET_BITS_DEF,
    parameter int M_WIDTH     = 48
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  u8d_pkg::u8d_qstat_t    qstat,
    input  u8d_pkg::u8d_class_t    cls,
    input  logic [OFFSET_BITS-1:0] offset,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_WIDTH-1:0]     m_tdata,
    output logic                   m_tlast,
    output logic [0:0]             m_tuser
);
    import u8d_pkg::*;

    logic [1:0]             pend_reg, pend_next;
    logic [CP_BITS-1:0]     part_reg, part_next;
    logic [LEN_BITS-1:0]    size_reg, size_next;
    u8d_chk_t               chk_reg, chk_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic                   skip_reg, skip_next;

    logic                   vld_reg, vld_next;
    logic [CP_BITS-1:0]     cp_reg, cp_next;
    logic [LEN_BITS-1:0]    len_reg, len_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic                   sp_reg, sp_next, lb_reg, lb_next;
    logic                   bad_reg, bad_next, done_reg, done_next;

    logic                   ok, first, emit, bad;
    logic [CP_BITS-1:0]     acc;
    logic [OFFSET_BITS-1:0] cs;

    assign pop      = !qstat.empty && (!vld_reg || m_tready);
    assign m_tvalid = vld_reg;
    assign m_tlast  = done_reg;
    assign m_tuser  = bad_reg;
    assign m_tdata  = M_WIDTH'({lb_reg, sp_reg, off_reg, len_reg, cp_reg});

    always_comb begin
        pend_next  = pend_reg;
        part_next  = part_reg;
        size_next  = size_reg;
        chk_next   = chk_reg;
        start_next = start_reg;
        skip_next  = skip_reg;
        cp_next    = cp_reg;
        len_next   = len_reg;
        off_next   = off_reg;
        sp_next    = sp_reg;
        lb_next    = lb_reg;
        bad_next   = bad_reg;
        done_next  = done_reg;
        emit       = 1'b0;
        bad        = 1'b0;
        ok         = 1'b1;
        acc        = {part_reg[CP_BITS-7:0], cls.data[5:0]};
        first      = ({1'b0, pend_reg} + 3'd1) == size_reg;
        cs         = (pend_reg == 2'd0) ? offset : start_reg;
        vld_next   = m_tready ? 1'b0 : vld_reg;

        if (pop && skip_reg) begin
            if (cls.last)
                skip_next = 1'b0;
        end else if (pop) begin
            start_next = cs;
            cp_next    = '0;
            len_next   = '0;
            if (pend_reg == 2'd0) begin
                chk_next = cls.chk;
                unique case (cls.kind)
                    CLS_ASCII: begin
                        cp_next  = CP_BITS'(cls.data);
                        len_next = LEN_BITS'(1);
                        emit     = 1'b1;
                    end
                    CLS_LEAD2: begin
                        part_next = CP_BITS'(cls.data[4:0]);
                        size_next = LEN_BITS'(2);
                        pend_next = 2'd1;
                    end
                    CLS_LEAD3: begin
                        part_next = CP_BITS'(cls.data[3:0]);
                        size_next = LEN_BITS'(3);
                        pend_next = 2'd2;
                    end
                    CLS_LEAD4: begin
                        part_next = CP_BITS'(cls.data[2:0]);
                        size_next = LEN_BITS'(4);
                        pend_next = 2'd3;
                    end
                    default: bad = 1'b1;
                endcase
            end else begin
                ok = cls.cont;
                if (first) begin
                    unique case (chk_reg)
                        CHK_E0:  ok = ok && !cls.lt_a0;
                        CHK_ED:  ok = ok && cls.lt_a0;
                        CHK_F0:  ok = ok && !cls.lt_90;
                        CHK_F4:  ok = ok && !cls.gt_8f;
                        default: ok = ok;
                    endcase
                end
                if (!ok) begin
                    bad = 1'b1;
                end else begin
                    part_next = acc;
                    pend_next = pend_reg - 2'd1;
                    if (pend_reg == 2'd1) begin
                        cp_next  = acc;
                        len_next = size_reg;
                        emit     = 1'b1;
                    end
                end
            end

            // text ends inside a sequence
            if (!bad && !emit && cls.last)
                bad = 1'b1;

            if (bad || emit) begin
                vld_next  = 1'b1;
                off_next  = cs;
                bad_next  = bad;
                done_next = cls.last;
                pend_next = 2'd0;
                part_next = '0;
                size_next = '0;
                chk_next  = CHK_NONE;
                if (bad) begin
                    cp_next   = '0;
                    len_next  = '0;
                    skip_next = !cls.last;
                end
                sp_next = !bad && in_space_set(cp_next);
                lb_next = !bad && is_break(cp_next);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg  <= '0;
            part_reg  <= '0;
            size_reg  <= '0;
            chk_reg   <= CHK_NONE;
            start_reg <= '0;
            skip_reg  <= 1'b0;
            vld_reg   <= 1'b0;
        end else begin
            pend_reg  <= pend_next;
            part_reg  <= part_next;
            size_reg  <= size_next;
            chk_reg   <= chk_next;
            start_reg <= start_next;
            skip_reg  <= skip_next;
            vld_reg   <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        cp_reg   <= cp_next;
        len_reg  <= len_next;
        off_reg  <= off_next;
        sp_reg   <= sp_next;
        lb_reg   <= lb_next;
        bad_reg  <= bad_next;
        done_reg <= done_next;
    end

endmodule

// File: hdl/utf8_strict_decoder.sv
// top level of the strict utf-8 decoder: classifier, queue and sequence decoder
// depends on u8d_pkg, u8d_front, u8d_fifo and u8d_back
//
//  channel  dir  tdata                                        tlast        tuser
//  s_       in   data_byte[7:0]                               end_of_text  -
//  m_       out  code_point, byte_count, start_offset,        text_done    bad_sequence
//                is_space, is_line_break (zero padded)
//
// one byte per cycle sustained while m_tready is high; a byte is loaded into the result
// register from the queue (classify into the queue, decode into the output register)
// every byte passes through the two-entry queue, which lets the classifier keep
// taking bytes while a result waits on m_tready
// reset (aresetn low, synchronous) empties the queue and output and zeroes the offset
// a stalled result holds the decoder; the front stops only when the queue is full
module utf8_strict_decoder #(
    parameter int OFFSET_BITS = u8d_pkg::OFFSET_BITS_DEF
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    input  logic [7:0]                                  s_tdata,  // [7:0] data_byte
    input  logic                                        s_tlast,  // end_of_text
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // [20:0] code_point, [23:21] byte_count, [OFFSET_BITS+23:24] start_offset,
    // then is_space, is_line_break, zero fill
    output logic [((OFFSET_BITS+26+7)/8)*8-1:0]         m_tdata,
    output logic                                        m_tlast,  // text_done
    output logic [0:0]                                  m_tuser   // [0] bad_sequence
);
    import u8d_pkg::*;

    localparam int M_WIDTH = ((OFFSET_BITS + 26 + 7) / 8) * 8;
    localparam int Q_WIDTH = $bits(u8d_class_t) + OFFSET_BITS;

    u8d_qstat_t             qstat;
    logic                   push, pop;
    u8d_class_t             f_cls, b_cls;
    logic [OFFSET_BITS-1:0] f_off, b_off;
    logic [Q_WIDTH-1:0]     q_din, q_dout;

    // byte classes and running offset
    u8d_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .qstat    (qstat),
        .push     (push),
        .cls      (f_cls),
        .offset   (f_off)
    );

    assign q_din = {f_off, f_cls};

    // decoupling queue
    u8d_fifo #(.WIDTH(Q_WIDTH), .DEPTH(QUEUE_DEPTH)) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     (q_din),
        .pop     (pop),
        .dout    (q_dout),
        .qstat   (qstat)
    );

    assign b_cls = q_dout[$bits(u8d_class_t)-1:0];
    assign b_off = q_dout[Q_WIDTH-1:$bits(u8d_class_t)];

    // sequence decoding and result register
    u8d_back #(.OFFSET_BITS(OFFSET_BITS), .M_WIDTH(M_WIDTH)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .qstat    (qstat),
        .cls      (b_cls),
        .offset   (b_off),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
